@@ hdl/hsfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_pkg
// Shared constants, types and the CRC-8 byte update for the sensor reply
// frame decoder.
// ----------------------------------------------------------------------------
package hsfd_pkg;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Byte positions inside one reply
  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  // Scaling constants
  localparam logic [30:0] TEMP_GAIN = 31'd17500;
  localparam logic [29:0] HUM_GAIN  = 30'd10000;
  localparam logic [14:0] TEMP_OFFSET   = 15'd4500;
  localparam logic [14:0] TEMP_RAW_HIGH = 15'd17000;  // scaled 12500 + 4500
  localparam logic [14:0] TEMP_RAW_LOW  = 15'd500;    // scaled -4000 + 4500
  localparam logic signed [14:0] TEMP_MAX = 15'sd12500;
  localparam logic signed [14:0] TEMP_MIN = -15'sd4000;
  localparam logic [13:0] HUM_MAX = 14'd10000;

  typedef struct packed {
    logic        done;        // this beat closes a reply
    logic        status;      // 1: a checksum mismatch
    logic [15:0] temp_word;
    logic [15:0] humid_word;
  } frame_t;

  // CRC-8, MSB first, one byte
  function automatic logic [7:0] crc8_byte(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] v;
    v = acc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage
`default_nettype wire

@@ hdl/hsfd_frame.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_frame
// Tracks the byte position of a reply, runs the CRC-8 over each word and
// holds the raw words. Reports the closing beat of a reply combinationally.
// ----------------------------------------------------------------------------
module hsfd_frame (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire logic [7:0]     rx_byte,
  input  wire logic           first_byte,
  output hsfd_pkg::frame_t    frame
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  check_r, check_nxt;
  logic        temp_ok_r, temp_ok_nxt;
  logic [15:0] temp_word_r, temp_word_nxt;
  logic [15:0] humid_word_r, humid_word_nxt;
  logic [2:0]  pos_eff;
  logic [7:0]  check_eff;
  logic [7:0]  crc_upd;

  always_comb begin
    // a start mark or a stray code restarts the reply
    if (first_byte || (pos_r > hsfd_pkg::POS_H_CRC)) begin
      pos_eff   = hsfd_pkg::POS_T_MSB;
      check_eff = hsfd_pkg::CRC_INIT;
    end else begin
      pos_eff   = pos_r;
      check_eff = check_r;
    end
  end

  assign crc_upd = hsfd_pkg::crc8_byte(check_eff, rx_byte);

  always_comb begin
    pos_nxt        = pos_eff + 3'd1;
    check_nxt      = crc_upd;
    temp_ok_nxt    = temp_ok_r;
    temp_word_nxt  = temp_word_r;
    humid_word_nxt = humid_word_r;
    frame.done       = 1'b0;
    frame.status     = 1'b0;
    frame.temp_word  = temp_word_r;
    frame.humid_word = humid_word_r;
    case (pos_eff)
      hsfd_pkg::POS_T_MSB: begin
        temp_word_nxt = {rx_byte, temp_word_r[7:0]};
      end
      hsfd_pkg::POS_T_LSB: begin
        temp_word_nxt = {temp_word_r[15:8], rx_byte};
      end
      hsfd_pkg::POS_T_CRC: begin
        temp_ok_nxt = (check_eff == rx_byte);
        check_nxt   = hsfd_pkg::CRC_INIT;
      end
      hsfd_pkg::POS_H_MSB: begin
        humid_word_nxt = {rx_byte, humid_word_r[7:0]};
      end
      hsfd_pkg::POS_H_LSB: begin
        humid_word_nxt = {humid_word_r[15:8], rx_byte};
      end
      default: begin
        frame.done   = 1'b1;
        frame.status = !(temp_ok_r && (check_eff == rx_byte));
        pos_nxt      = hsfd_pkg::POS_T_MSB;
        check_nxt    = hsfd_pkg::CRC_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= hsfd_pkg::POS_T_MSB;
      check_r   <= hsfd_pkg::CRC_INIT;
      temp_ok_r <= 1'b0;
    end else if (step) begin
      pos_r     <= pos_nxt;
      check_r   <= check_nxt;
      temp_ok_r <= temp_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      temp_word_r  <= temp_word_nxt;
      humid_word_r <= humid_word_nxt;
    end
  end

endmodule
`default_nettype wire

@@ hdl/hsfd_scale.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_scale
// Scales the raw words to hundredths: one constant multiply each, then an
// exact floor division by 65535 as (p + (p >> 16) + 1) >> 16.
// ----------------------------------------------------------------------------
module hsfd_scale (
  input  wire logic [15:0]        temp_word,
  input  wire logic [15:0]        humid_word,
  output logic signed [14:0]      temperature_centi,
  output logic [13:0]             humidity_centi
);

  logic [30:0] temp_prod;
  logic [31:0] temp_sum;
  logic [14:0] temp_q;
  logic [29:0] hum_prod;
  logic [31:0] hum_sum;

  assign temp_prod = {15'd0, temp_word} * hsfd_pkg::TEMP_GAIN;
  assign temp_sum  = {1'b0, temp_prod} + {17'd0, temp_prod[30:16]} + 32'd1;
  assign temp_q    = temp_sum[30:16];

  assign hum_prod = {14'd0, humid_word} * hsfd_pkg::HUM_GAIN;
  assign hum_sum  = {2'd0, hum_prod} + {18'd0, hum_prod[29:16]} + 32'd1;
  assign humidity_centi = hum_sum[29:16];

  always_comb begin
    // clamp on the unsigned quotient before removing the offset
    if (temp_q > hsfd_pkg::TEMP_RAW_HIGH) begin
      temperature_centi = hsfd_pkg::TEMP_MAX;
    end else if (temp_q < hsfd_pkg::TEMP_RAW_LOW) begin
      temperature_centi = hsfd_pkg::TEMP_MIN;
    end else begin
      temperature_centi = $signed(temp_q - hsfd_pkg::TEMP_OFFSET);
    end
  end

endmodule
`default_nettype wire

@@ hdl/humidity_sensor_frame_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_sensor_frame_decoder
// Decodes a six-byte temperature/humidity reply with CRC-8 word checks.
// ----------------------------------------------------------------------------
// The result is registered: the humidity CRC byte passes the input register, then the result register.
// Throughput: one byte per cycle while no result is held back; an input register and a result register
//   bound a single pass of CRC, position and scaling logic.
// A held result stalls intake only when the next reply closes behind it.
// Reset clears the position, the running check and both valid flags.
module humidity_sensor_frame_decoder (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         in_rx_byte,
  input  wire logic               in_first_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [14:0]      out_temperature_centi,
  output logic [13:0]             out_humidity_centi,
  output logic [15:0]             out_temperature_word,
  output logic [15:0]             out_humidity_word,
  output logic                    out_frame_status
);

  logic              in_vld_r;
  logic [7:0]        byte_r;
  logic              first_r;
  logic              advance;
  logic              load_out;
  hsfd_pkg::frame_t  frame;
  logic signed [14:0] temp_centi;
  logic [13:0]       hum_centi;
  logic              out_vld_r;
  logic signed [14:0] temp_centi_r;
  logic [13:0]       hum_centi_r;
  logic [15:0]       temp_word_r;
  logic [15:0]       hum_word_r;
  logic              status_r;

  // hold the registered beat only when it closes a reply and the result slot is full and not being taken
  assign advance  = in_vld_r && (!frame.done || !out_vld_r || out_ready);
  assign load_out = advance && frame.done;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      byte_r  <= in_rx_byte;
      first_r <= in_first_byte;
    end
  end

  hsfd_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .rx_byte    (byte_r),
    .first_byte (first_r),
    .frame      (frame)
  );

  hsfd_scale u_scale (
    .temp_word         (frame.temp_word),
    .humid_word        (frame.humid_word),
    .temperature_centi (temp_centi),
    .humidity_centi    (hum_centi)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (load_out) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      temp_centi_r <= temp_centi;
      hum_centi_r  <= hum_centi;
      temp_word_r  <= frame.temp_word;
      hum_word_r   <= frame.humid_word;
      status_r     <= frame.status;
    end
  end

  assign out_valid             = out_vld_r;
  assign out_temperature_centi = temp_centi_r;
  assign out_humidity_centi    = hum_centi_r;
  assign out_temperature_word  = temp_word_r;
  assign out_humidity_word     = hum_word_r;
  assign out_frame_status      = status_r;

  // a closing beat always lands in the result register
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |=> out_valid)
    else $error("closing beat did not produce a result");

  // never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !load_out)
    else $error("pending result overwritten");

  // scaled values stay inside their ranges
  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_humidity_centi <= hsfd_pkg::HUM_MAX) &&
                   (out_temperature_centi <= hsfd_pkg::TEMP_MAX) &&
                   (out_temperature_centi >= hsfd_pkg::TEMP_MIN)))
    else $error("scaled value out of range");

  // a registered beat that is not advanced stays put
  a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> (in_vld_r && $stable(byte_r) && $stable(first_r)))
    else $error("stalled beat lost");

endmodule
`default_nettype wire
